// File: design/mtsa_pkg.sv
// shared constants and the per-item context carried through the divider stages
package mtsa_pkg;

	localparam int PIPE_BITS = 1;
	localparam int BANK_BITS = 2;
	localparam int SWZ_BITS  = PIPE_BITS + BANK_BITS;

	// surface register indexes on the configuration port
	localparam logic [2:0] REG_BPE       = 3'd0;
	localparam logic [2:0] REG_PITCH     = 3'd1;
	localparam logic [2:0] REG_HEIGHT    = 3'd2;
	localparam logic [2:0] REG_SAMPLES   = 3'd3;
	localparam logic [2:0] REG_MODE      = 3'd4;
	localparam logic [2:0] REG_SWIZZLE   = 3'd5;
	localparam logic [2:0] REG_ROTATION  = 3'd6;
	localparam logic [2:0] REG_SWAP_W    = 3'd7;

	// layout codes, low three bits of the mode register
	localparam logic [2:0] LAYOUT_THIN1    = 3'd0;
	localparam logic [2:0] LAYOUT_THIN2    = 3'd1;
	localparam logic [2:0] LAYOUT_THIN4    = 3'd2;
	localparam logic [2:0] LAYOUT_SW_THIN1 = 3'd3;
	localparam logic [2:0] LAYOUT_SW_THIN2 = 3'd4;
	localparam logic [2:0] LAYOUT_SW_THIN4 = 3'd5;
	localparam logic [2:0] LAYOUT_THICK    = 3'd6;
	localparam logic [2:0] LAYOUT_SW_THICK = 3'd7;

	// bank swap pattern, indexed by the swap index modulo the bank count
	localparam logic [BANK_BITS-1:0] SWAP_PATTERN [4] = '{2'd0, 2'd1, 2'd3, 2'd2};

	// width and radix of the pipelined dividers
	localparam int DIV_WIDTH = 20;
	localparam int DIV_STEP  = 2;

	typedef struct packed {
		logic [19:0]          elem;
		logic                 split;
		logic [3:0]           splits;
		logic [SWZ_BITS-1:0]  bp0;
		logic [SWZ_BITS-1:0]  rot;
		logic [BANK_BITS-1:0] swp;
		logic [12:0]          slice;
		logic [34:0]          sb;
		logic [31:0]          macro_off;
	} addr_ctx_t;

endpackage

// File: design/mtsa_div.sv
// pipelined restoring divider, STEP quotient bits per stage, with sideband payload
module mtsa_div #(
	parameter int WIDTH = 20,
	parameter int STEP = 2,
	parameter int LANES = 1,
	parameter type payload_t = logic
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic [LANES-1:0][WIDTH-1:0]      num,
	input  logic [LANES-1:0][WIDTH-1:0]      den,
	input  payload_t                         in_pay,
	output logic                             out_valid,
	output logic [LANES-1:0][WIDTH-1:0]      quo,
	output logic [LANES-1:0][WIDTH-1:0]      rem,
	output payload_t                         out_pay
);

	localparam int NSTG = WIDTH / STEP;

	logic                          vld_s [NSTG+1];
	logic [LANES-1:0][WIDTH-1:0]   num_s [NSTG+1];
	logic [LANES-1:0][WIDTH-1:0]   den_s [NSTG+1];
	logic [LANES-1:0][WIDTH-1:0]   rem_s [NSTG+1];
	logic [LANES-1:0][WIDTH-1:0]   quo_s [NSTG+1];
	payload_t                      pay_s [NSTG+1];

	assign vld_s[0] = in_valid;
	assign num_s[0] = num;
	assign den_s[0] = den;
	assign rem_s[0] = '0;
	assign quo_s[0] = '0;
	assign pay_s[0] = in_pay;

	for (genvar k = 0; k < NSTG; k++) begin : g_stage
		logic [LANES-1:0][WIDTH-1:0] num_d, rem_d, quo_d;

		always_comb begin
			logic [WIDTH:0]   t;
			logic [WIDTH-1:0] n, r, q;
			for (int l = 0; l < LANES; l++) begin
				n = num_s[k][l];
				r = rem_s[k][l];
				q = quo_s[k][l];
				for (int j = 0; j < STEP; j++) begin
					t = {r, n[WIDTH-1]};
					n = n << 1;
					if (t >= {1'b0, den_s[k][l]}) begin
						t = t - {1'b0, den_s[k][l]};
						q = {q[WIDTH-2:0], 1'b1};
					end else begin
						q = {q[WIDTH-2:0], 1'b0};
					end
					r = t[WIDTH-1:0];
				end
				num_d[l] = n;
				rem_d[l] = r;
				quo_d[l] = q;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k+1] <= num_d;
				den_s[k+1] <= den_s[k];
				rem_s[k+1] <= rem_d;
				quo_s[k+1] <= quo_d;
				pay_s[k+1] <= pay_s[k];
			end
		end
	end

	assign out_valid = vld_s[NSTG];
	assign quo       = quo_s[NSTG];
	assign rem       = rem_s[NSTG];
	assign out_pay   = pay_s[NSTG];

endmodule

// File: design/macro_tiled_surface_address.sv
// Macro-tiled surface address generator, 2 pipes and 4 banks.
//
// Input channel s_axis carries one texel coordinate per word; output channel
// m_axis returns its 32-bit byte offset, one word per input word, in order.
// Surface registers are written through cfg_we/cfg_index/cfg_wdata, which the
// user must do only while no word is in flight; the block does not enforce it.
//
// A write takes effect at the next clock edge. A word is accepted every cycle
// while the output is not stalled. It passes four stages of interleave, sample
// split and slice/macro tile products, a 10-stage divider for the split chunk
// and bank-swap index, one fix-up stage, a second 10-stage divider for the
// sample slice, and four stages for the slice offset product and the pipe/bank
// insertion. The dividers retire two quotient bits per stage, setting the depth.
//
// Reset clears all pipeline valid bits and loads the default surface setup.
// When m_axis_tready is low with a result waiting, the whole pipeline holds
// and s_axis_tready drops in the same cycle; nothing is dropped or repeated.
module macro_tiled_surface_address #(
	parameter int INTERLEAVE_BITS = 8,
	parameter int SPLIT_BYTES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// coord_x[13:0], coord_y[27:14], slice_index[40:28], sample_index[43:41], zero pad
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// byte_offset[31:0]
	output logic [31:0] m_axis_tdata
);

	import mtsa_pkg::*;

	localparam logic [7:0] BPE_8   = 8'd8;
	localparam logic [7:0] BPE_16  = 8'd16;
	localparam logic [7:0] BPE_64  = 8'd64;
	localparam logic [7:0] BPE_128 = 8'd128;

	localparam int S8 = SPLIT_BYTES / 8;

	// ---------------- configuration registers ----------------
	logic [7:0]  bpe_q;
	logic [14:0] pitch_q, height_q, swap_w_q;
	logic [3:0]  nsamp_q, mode_q;
	logic [2:0]  swz_q, rot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpe_q    <= 8'd32;
			pitch_q  <= 15'd256;
			height_q <= 15'd256;
			nsamp_q  <= 4'd1;
			mode_q   <= 4'd0;
			swz_q    <= 3'd0;
			rot_q    <= 3'd0;
			swap_w_q <= 15'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BPE:      bpe_q    <= cfg_wdata[7:0];
				REG_PITCH:    pitch_q  <= cfg_wdata;
				REG_HEIGHT:   height_q <= cfg_wdata;
				REG_SAMPLES:  nsamp_q  <= cfg_wdata[3:0];
				REG_MODE:     mode_q   <= cfg_wdata[3:0];
				REG_SWIZZLE:  swz_q    <= cfg_wdata[2:0];
				REG_ROTATION: rot_q    <= cfg_wdata[2:0];
				REG_SWAP_W:   swap_w_q <= cfg_wdata;
				default:      ;
			endcase
		end
	end

	// decoded surface setup, which the user must keep stable while words are in flight
	logic [3:0]  ns;
	logic        depth, thick, swapped;
	logic [2:0]  mtp_sh, mth_sh;
	logic [14:0] swap_w;

	always_comb begin
		ns      = (nsamp_q == 4'd0) ? 4'd1 : nsamp_q;
		depth   = mode_q[3];
		swap_w  = (swap_w_q == 15'd0) ? 15'd1 : swap_w_q;
		thick   = 1'b0;
		swapped = 1'b0;
		mtp_sh  = 3'd5;
		mth_sh  = 3'd4;
		unique case (mode_q[2:0])
			LAYOUT_THIN1:    ;
			LAYOUT_THIN2:    begin mtp_sh = 3'd4; mth_sh = 3'd5; end
			LAYOUT_THIN4:    begin mtp_sh = 3'd3; mth_sh = 3'd6; end
			LAYOUT_SW_THIN1: swapped = 1'b1;
			LAYOUT_SW_THIN2: begin swapped = 1'b1; mtp_sh = 3'd4; mth_sh = 3'd5; end
			LAYOUT_SW_THIN4: begin swapped = 1'b1; mtp_sh = 3'd3; mth_sh = 3'd6; end
			LAYOUT_THICK:    thick = 1'b1;
			LAYOUT_SW_THICK: begin thick = 1'b1; swapped = 1'b1; end
			default:         ;
		endcase
	end

	// samples per split, by element size, before the thickness divide
	logic [9:0] ps_lut [256];
	assign ps_lut[0] = '0;
	for (genvar g = 1; g < 256; g++) begin : g_ps
		localparam int Den = g;
		assign ps_lut[g] = 10'(S8 / Den);
	end

	// split count by sample count and samples per split, never below one
	logic [3:0] split_lut [256];
	for (genvar gn = 0; gn < 16; gn++) begin : g_sn
		for (genvar gp = 0; gp < 16; gp++) begin : g_sp
			localparam int Num = gn;
			localparam int Den = (gp == 0) ? 1 : gp;
			localparam int Quo = Num / Den;
			assign split_lut[gn*16 + gp] = 4'((Quo == 0) ? 1 : Quo);
		end
	end

	function automatic logic [7:0] micro_index(input logic [2:0] x, input logic [2:0] y,
	                                           input logic [1:0] z, input logic [7:0] bpe,
	                                           input logic dep, input logic thk);
		logic [5:0] b;
		priority if (dep)            b = {y[2], x[2], y[1], x[1], y[0], x[0]};
		else if (bpe == BPE_8)       b = {y[2], y[0], y[1], x[2], x[1], x[0]};
		else if (bpe == BPE_16)      b = {y[2], y[1], y[0], x[2], x[1], x[0]};
		else if (bpe == BPE_64)      b = {y[2], y[1], x[2], x[1], y[0], x[0]};
		else if (bpe == BPE_128)     b = {y[2], y[1], x[2], x[1], x[0], y[0]};
		else                         b = {y[2], y[1], x[2], y[0], x[1], x[0]};
		return {(thk ? z : 2'b00), b};
	endfunction

	logic adv;
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	logic [13:0] in_x, in_y;
	logic [12:0] in_slice;
	logic [2:0]  in_sample;
	assign in_x      = s_axis_tdata[13:0];
	assign in_y      = s_axis_tdata[27:14];
	assign in_slice  = s_axis_tdata[40:28];
	assign in_sample = s_axis_tdata[43:41];

	// ---------------- stage 1: interleave and first products ----------------
	logic        v1;
	logic [7:0]  pix_s1;
	logic [11:0] nb_s1;
	logic [15:0] bpe_pix_s1;
	logic [10:0] bpe_smp_s1;
	logic [2:0]  bp0_s1, rot_s1;
	logic [13:0] xm_s1;
	logic [10:0] mtx_s1;
	logic [21:0] mprod_s1;
	logic [29:0] hp_s1;
	logic [12:0] slice_s1;

	logic [7:0]  pix_d;
	logic [2:0]  bp0_d, rot_d;
	logic [12:0] slice_in;
	logic [1:0]  bk_raw;

	always_comb begin
		pix_d    = micro_index(in_x[2:0], in_y[2:0], in_slice[1:0], bpe_q, depth, thick);
		bk_raw   = in_y[5:4];
		bp0_d    = {({bk_raw[0], bk_raw[1]} ^ in_x[4:3]), in_y[3] ^ in_x[3]};
		slice_in = thick ? (in_slice >> 2) : in_slice;
		rot_d    = swz_q + 3'(slice_in[2:0] * rot_q);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1     <= pix_d;
			nb_s1      <= 12'(ns) * 12'(bpe_q);
			bpe_pix_s1 <= 16'(bpe_q) * 16'(pix_d);
			bpe_smp_s1 <= 11'(bpe_q) * 11'(in_sample);
			bp0_s1     <= bp0_d;
			rot_s1     <= rot_d;
			xm_s1      <= (in_x >> mtp_sh) << mtp_sh;
			mtx_s1     <= 11'(in_x >> mtp_sh);
			mprod_s1   <= 22'(pitch_q >> mtp_sh) * 22'(in_y >> mth_sh);
			hp_s1      <= 30'(height_q) * 30'(pitch_q);
			slice_s1   <= in_slice;
		end
	end

	// ---------------- stage 2: element offset and sample split ----------------
	logic        v2;
	logic [19:0] mt_bits_s2, elem_s2;
	logic        split_s2;
	logic [3:0]  nsf_s2, splits_s2;
	logic [37:0] hpb_s2;
	logic [22:0] moff_idx_s2;
	logic [2:0]  bp0_s2, rot_s2;
	logic [13:0] xm_s2;
	logic [12:0] slice_s2;

	logic        split_d;
	logic [9:0]  ps_full, ps;
	logic [19:0] elem_d;

	always_comb begin
		split_d = (ns > 4'd1) && ((20'(nb_s1) << (thick ? 5 : 3)) > 20'(SPLIT_BYTES));
		ps_full = thick ? (ps_lut[bpe_q] >> 2) : ps_lut[bpe_q];
		ps      = (ps_full == 10'd0) ? 10'd1 : ps_full;
		if (depth) elem_d = 20'(nb_s1) * 20'(pix_s1) + 20'(bpe_smp_s1);
		else       elem_d = 20'(bpe_pix_s1) + (20'(bpe_smp_s1) << (thick ? 8 : 6));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mt_bits_s2  <= 20'(nb_s1) << (thick ? 8 : 6);
			elem_s2     <= elem_d;
			split_s2    <= split_d;
			nsf_s2      <= split_d ? ps[3:0] : ns;
			splits_s2   <= split_d ? split_lut[{ns, ps[3:0]}] : 4'd1;
			hpb_s2      <= 38'(hp_s1) * 38'(bpe_q);
			moff_idx_s2 <= 23'(mtx_s1) + 23'(mprod_s1);
			bp0_s2      <= bp0_s1;
			rot_s2      <= rot_s1;
			xm_s2       <= xm_s1;
			slice_s2    <= slice_s1;
		end
	end

	// ---------------- stage 3: slice and macro tile size products ----------------
	logic        v3;
	logic [41:0] sbp_s3;
	logic [11:0] nbf_s3;
	logic [19:0] mt_bits_s3, elem_s3;
	logic        split_s3;
	logic [3:0]  splits_s3;
	logic [22:0] moff_idx_s3;
	logic [2:0]  bp0_s3, rot_s3;
	logic [13:0] xm_s3;
	logic [12:0] slice_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			sbp_s3      <= 42'(hpb_s2) * 42'(nsf_s2);
			nbf_s3      <= 12'(nsf_s2) * 12'(bpe_q);
			mt_bits_s3  <= mt_bits_s2;
			elem_s3     <= elem_s2;
			split_s3    <= split_s2;
			splits_s3   <= splits_s2;
			moff_idx_s3 <= moff_idx_s2;
			bp0_s3      <= bp0_s2;
			rot_s3      <= rot_s2;
			xm_s3       <= xm_s2;
			slice_s3    <= slice_s2;
		end
	end

	// ---------------- stage 4: slice bytes and macro tile offset ----------------
	logic        v4;
	logic [19:0] mt_bits_s4;
	logic [13:0] xm_s4;
	addr_ctx_t   ctx_s4;

	logic [43:0] sbp_sh;
	logic [44:0] sb_round;
	logic [19:0] macro_bytes;
	logic [42:0] moff_full;
	addr_ctx_t   ctx4_d;

	always_comb begin
		sbp_sh      = 44'(sbp_s3) << (thick ? 2 : 0);
		sb_round    = 45'(sbp_sh) + 45'd7;
		macro_bytes = 20'(nbf_s3) << (thick ? 8 : 6);
		moff_full   = 43'(moff_idx_s3) * 43'(macro_bytes);
		ctx4_d.elem      = elem_s3;
		ctx4_d.split     = split_s3;
		ctx4_d.splits    = splits_s3;
		ctx4_d.bp0       = bp0_s3;
		ctx4_d.rot       = rot_s3;
		ctx4_d.swp       = '0;
		ctx4_d.slice     = slice_s3;
		ctx4_d.sb        = sb_round[37:3];
		ctx4_d.macro_off = moff_full[31:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mt_bits_s4 <= mt_bits_s3;
			xm_s4      <= xm_s3;
			ctx_s4     <= ctx4_d;
		end
	end

	// ---------------- divider 1: split chunk and bank-swap index ----------------
	logic [1:0][DIV_WIDTH-1:0] d1_num, d1_den, d1_quo, d1_rem;
	logic                      d1_valid;
	addr_ctx_t                 d1_ctx;

	assign d1_num[0] = mt_bits_s4;
	assign d1_den[0] = DIV_WIDTH'(ctx_s4.splits);
	assign d1_num[1] = DIV_WIDTH'(xm_s4);
	assign d1_den[1] = DIV_WIDTH'(swap_w);

	mtsa_div #(
		.WIDTH     (DIV_WIDTH),
		.STEP      (DIV_STEP),
		.LANES     (2),
		.payload_t (addr_ctx_t)
	) u_div_chunk (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v4),
		.num       (d1_num),
		.den       (d1_den),
		.in_pay    (ctx_s4),
		.out_valid (d1_valid),
		.quo       (d1_quo),
		.rem       (d1_rem),
		.out_pay   (d1_ctx)
	);

	// ---------------- stage 5: chunk guard and swap pattern ----------------
	logic        v5;
	logic [19:0] chunk_s5;
	addr_ctx_t   ctx_s5;
	addr_ctx_t   ctx5_d;

	always_comb begin
		ctx5_d     = d1_ctx;
		ctx5_d.swp = swapped ? SWAP_PATTERN[d1_quo[1][1:0]] : '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			chunk_s5 <= (d1_quo[0] == '0) ? 20'd1 : d1_quo[0];
			ctx_s5   <= ctx5_d;
		end
	end

	// ---------------- divider 2: sample slice and offset within it ----------------
	logic [0:0][DIV_WIDTH-1:0] d2_num, d2_den, d2_quo, d2_rem;
	logic                      d2_valid;
	addr_ctx_t                 d2_ctx;

	assign d2_num[0] = ctx_s5.elem;
	assign d2_den[0] = chunk_s5;

	mtsa_div #(
		.WIDTH     (DIV_WIDTH),
		.STEP      (DIV_STEP),
		.LANES     (1),
		.payload_t (addr_ctx_t)
	) u_div_slice (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v5),
		.num       (d2_num),
		.den       (d2_den),
		.in_pay    (ctx_s5),
		.out_valid (d2_valid),
		.quo       (d2_quo),
		.rem       (d2_rem),
		.out_pay   (d2_ctx)
	);

	// ---------------- stage 6: pipe/bank and slice index ----------------
	logic        v6;
	logic [16:0] elemf_s6;
	logic [2:0]  pb_s6;
	logic [20:0] factor_s6;
	logic [34:0] sb_s6;
	logic [31:0] moff_s6;

	logic [19:0] sslice, elem_sel;
	logic [2:0]  bp;
	logic [20:0] fsum;

	always_comb begin
		sslice   = d2_ctx.split ? d2_quo[0] : '0;
		elem_sel = d2_ctx.split ? d2_rem[0] : d2_ctx.elem;
		bp       = d2_ctx.bp0 ^ 3'({1'b0, sslice[1:0]} * 3'd6) ^ d2_ctx.rot;
		fsum     = 21'(sslice) + 21'(17'(d2_ctx.splits) * 17'(d2_ctx.slice));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			elemf_s6  <= elem_sel[19:3];
			pb_s6     <= {bp[2:1] ^ d2_ctx.swp, bp[0]};
			factor_s6 <= thick ? (fsum >> 2) : fsum;
			sb_s6     <= d2_ctx.sb;
			moff_s6   <= d2_ctx.macro_off;
		end
	end

	// ---------------- stage 7: slice offset partial products ----------------
	logic        v7;
	logic [34:0] pl_s7;
	logic [18:0] ph_s7;
	logic [31:0] moff_s7;
	logic [16:0] elemf_s7;
	logic [2:0]  pb_s7;

	logic [50:0] pl_full;
	logic [23:0] ph_full;

	always_comb begin
		pl_full = 51'(sb_s6) * 51'(factor_s6[15:0]);
		ph_full = 24'(sb_s6[18:0]) * 24'(factor_s6[20:16]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pl_s7    <= pl_full[34:0];
			ph_s7    <= ph_full[18:0];
			moff_s7  <= moff_s6;
			elemf_s7 <= elemf_s6;
			pb_s7    <= pb_s6;
		end
	end

	// ---------------- stage 8: macro plus slice offset ----------------
	logic        v8;
	logic [34:0] tot_s8;
	logic [16:0] elemf_s8;
	logic [2:0]  pb_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			tot_s8   <= 35'(moff_s7) + pl_s7 + {ph_s7, 16'b0};
			elemf_s8 <= elemf_s7;
			pb_s8    <= pb_s7;
		end
	end

	// ---------------- stage 9: pipe/bank insertion, output word ----------------
	logic [31:0] ms;
	assign ms = tot_s8[34:3] + 32'(elemf_s8);

	always_ff @(posedge clk) begin
		if (adv) begin
			m_axis_tdata <= {ms[31-SWZ_BITS:INTERLEAVE_BITS], pb_s8, ms[INTERLEAVE_BITS-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1            <= 1'b0;
			v2            <= 1'b0;
			v3            <= 1'b0;
			v4            <= 1'b0;
			v5            <= 1'b0;
			v6            <= 1'b0;
			v7            <= 1'b0;
			v8            <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			v1            <= s_axis_tvalid;
			v2            <= v1;
			v3            <= v2;
			v4            <= v3;
			v5            <= d1_valid;
			v6            <= d2_valid;
			v7            <= v6;
			v8            <= v7;
			m_axis_tvalid <= v8;
		end
	end

endmodule

// File: design/mtsa_checker.sv
// port-level checks for the surface address generator, bound to the top level
module mtsa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	// a waiting result word is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	// a waiting result word keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// with the output side empty the block always takes a word
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input refused with empty output");

	// an output stall holds the whole pipe, so the input side must stop too
	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted during output stall");

	// no result can be pending while reset is held
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

endmodule

bind macro_tiled_surface_address mtsa_checker u_mtsa_checker (.*);

// File: tb/sv/tb.sv
// testbench for the macro-tiled surface address generator
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mtsa_pkg::*;

	localparam int INTERLEAVE_BITS = 8;
	localparam int SPLIT_BYTES = 2048;
	localparam int PIPE_LATENCY = 29;
	localparam int SETTLE_CYCLES = PIPE_LATENCY + 10;
	localparam int STALL_LIMIT = 4000;

	localparam logic MODE_DEPTH = 1'b1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [14:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;

	macro_tiled_surface_address uut (.*);

	always #10 clk = ~clk;

	// shadow copy of the surface registers
	logic [7:0]  sh_bpe;
	logic [14:0] sh_pitch, sh_height, sh_swap_width;
	logic [3:0]  sh_samples, sh_mode;
	logic [2:0]  sh_swizzle, sh_rotation;

	logic [31:0] offsets_due [$];
	int          mismatches = 0;
	int          words_sent = 0;
	int          words_checked = 0;
	int          surfaces_used = 0;
	bit          gaps_on = 1'b1;
	int          stall_left = 0;
	int          quiet_cycles = 0;

	function automatic logic [31:0] tiled_offset(input logic [13:0] cx, input logic [13:0] cy,
			input logic [12:0] cz, input logic [2:0] smp);
		logic [31:0] x, y, z, bpe, ns, thick, mt_bits, mt_bytes, pix, elem, splits, sslice;
		logic [31:0] per_sample, per_slice, chunk, pipe, bk, slice_in, bp, mtp, mth, mt_x;
		logic [31:0] macro_bytes, macro_off, ms, addr, w, idx;
		logic [2:0]  layout;
		logic        depth, swapped;
		logic [5:0]  mb;
		logic [63:0] slice_bytes, slice_off;
		x = cx; y = cy; z = cz;
		bpe = sh_bpe;
		ns = (sh_samples == 0) ? 32'd1 : 32'(sh_samples);
		layout = sh_mode[2:0];
		depth = sh_mode[3];
		thick = (layout >= LAYOUT_THICK) ? 32'd4 : 32'd1;
		swapped = (layout >= LAYOUT_SW_THIN1 && layout <= LAYOUT_SW_THIN4)
			|| layout == LAYOUT_SW_THICK;
		mt_bits = ns * bpe * thick * 32'd64;
		mt_bytes = mt_bits >> 3;
		if (depth)
			mb = {y[2], x[2], y[1], x[1], y[0], x[0]};
		else case (bpe)
			32'd8:   mb = {y[2], y[0], y[1], x[2], x[1], x[0]};
			32'd16:  mb = {y[2], y[1], y[0], x[2], x[1], x[0]};
			32'd64:  mb = {y[2], y[1], x[2], x[1], y[0], x[0]};
			32'd128: mb = {y[2], y[1], x[2], x[1], x[0], y[0]};
			default: mb = {y[2], y[1], x[2], y[0], x[1], x[0]};
		endcase
		pix = mb;
		if (thick > 1)
			pix = pix | {z[1:0], 6'd0};
		if (depth)
			elem = ns * bpe * pix + bpe * smp;
		else
			elem = bpe * pix + 32'(smp) * (mt_bits / ns);
		splits = 1;
		sslice = 0;
		if (ns > 1 && mt_bytes > SPLIT_BYTES) begin
			per_sample = mt_bytes / ns;
			per_slice = (per_sample != 0) ? 32'(SPLIT_BYTES) / per_sample : ns;
			if (per_slice == 0)
				per_slice = 1;
			splits = ns / per_slice;
			if (splits == 0)
				splits = 1;
			ns = per_slice;
			chunk = mt_bits / splits;
			if (chunk == 0)
				chunk = 1;
			sslice = elem / chunk;
			elem = elem % chunk;
		end
		elem = elem >> 3;
		pipe = ((y >> 3) ^ (x >> 3)) & 32'd1;
		bk = (y >> 4) & 32'd3;
		bk = (((bk >> 1) | (bk << 1)) ^ (x >> 3)) & 32'd3;
		slice_in = (layout >= LAYOUT_THICK) ? (z >> 2) : z;
		bp = pipe + 32'd2 * bk;
		bp = bp ^ ((32'd2 * sslice * 32'd3) ^ (32'(sh_swizzle) + slice_in * 32'(sh_rotation)));
		bp = bp % 32'd8;
		pipe = bp % 32'd2;
		bk = bp / 32'd2;
		slice_bytes = (64'(sh_height) * 64'(sh_pitch) * 64'(thick) * 64'(bpe) * 64'(ns)
			+ 64'd7) / 64'd8;
		slice_off = slice_bytes * 64'((sslice + splits * z) / thick);
		mtp = 32;
		mth = 16;
		if (layout == LAYOUT_THIN2 || layout == LAYOUT_SW_THIN2) begin
			mtp = mtp >> 1; mth = mth << 1;
		end else if (layout == LAYOUT_THIN4 || layout == LAYOUT_SW_THIN4) begin
			mtp = mtp >> 2; mth = mth << 2;
		end
		mt_x = x / mtp;
		macro_bytes = (ns * thick * bpe * mth * mtp + 32'd7) >> 3;
		macro_off = (mt_x + (32'(sh_pitch) / mtp) * (y / mth)) * macro_bytes;
		if (swapped) begin
			w = (sh_swap_width == 0) ? 32'd1 : 32'(sh_swap_width);
			idx = (mtp * mt_x) / w;
			bk = bk ^ 32'(SWAP_PATTERN[idx[1:0]]);
		end
		ms = 32'((64'(macro_off) + slice_off) >> SWZ_BITS);
		ms = ms + elem;
		addr = ((ms & ~32'((1 << INTERLEAVE_BITS) - 1)) << SWZ_BITS)
			| (ms & 32'((1 << INTERLEAVE_BITS) - 1));
		addr = addr | (pipe << INTERLEAVE_BITS) | (bk << (PIPE_BITS + INTERLEAVE_BITS));
		return addr;
	endfunction

	task automatic report_mismatch(input logic [31:0] got, input logic [31:0] want);
		mismatches++;
		$display("mismatch at %0t: byte_offset got %h expected %h", $time, got, want);
	endtask

	// result side: random stalls and in-order comparison
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				words_checked++;
				if (offsets_due.size() == 0) begin
					mismatches++;
					$display("unexpected word at %0t: byte_offset %h", $time, m_axis_tdata);
				end else begin
					if (m_axis_tdata !== offsets_due[0])
						report_mismatch(m_axis_tdata, offsets_due[0]);
					void'(offsets_due.pop_front());
				end
				stall_left = gaps_on ? $urandom_range(0, 15) : 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else
				m_axis_tready <= 1'b1;
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout at %0t with %0d words outstanding", $time, offsets_due.size());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic send_coord(input logic [13:0] x, input logic [13:0] y,
			input logic [12:0] z, input logic [2:0] smp);
		int gap;
		gap = gaps_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, smp, z, y, x};
		do @(posedge clk); while (!s_axis_tready);
		offsets_due.push_back(tiled_offset(x, y, z, smp));
		words_sent++;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (offsets_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [14:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic set_surface(input logic [7:0] bpe, input logic [14:0] pitch,
			input logic [14:0] height, input logic [3:0] samples, input logic [3:0] mode,
			input logic [2:0] swz, input logic [2:0] rot, input logic [14:0] swap_width);
		wait_idle();
		write_reg(REG_BPE, 15'(bpe));
		write_reg(REG_PITCH, pitch);
		write_reg(REG_HEIGHT, height);
		write_reg(REG_SAMPLES, 15'(samples));
		write_reg(REG_MODE, 15'(mode));
		write_reg(REG_SWIZZLE, 15'(swz));
		write_reg(REG_ROTATION, 15'(rot));
		write_reg(REG_SWAP_W, swap_width);
		cfg_we <= 1'b0;
		sh_bpe = bpe; sh_pitch = pitch; sh_height = height; sh_samples = samples;
		sh_mode = mode; sh_swizzle = swz; sh_rotation = rot; sh_swap_width = swap_width;
		surfaces_used++;
	endtask

	task automatic send_random_coord();
		send_coord(14'($urandom), 14'($urandom), 13'($urandom), 3'($urandom));
	endtask

	// default surface after reset, coordinate extremes
	task automatic test_reset_surface();
		sh_bpe = 32; sh_pitch = 256; sh_height = 256; sh_samples = 1;
		sh_mode = 0; sh_swizzle = 0; sh_rotation = 0; sh_swap_width = 256;
		send_coord(14'd0, 14'd0, 13'd0, 3'd0);
		send_coord(14'h3FFF, 14'h3FFF, 13'h1FFF, 3'd7);
		send_coord(14'h2AAA, 14'h1555, 13'h0AAA, 3'd5);
		send_coord(14'h1555, 14'h2AAA, 13'h1555, 3'd2);
	endtask

	// each layout and element size at least once, plus the corner cases
	task automatic test_layouts_and_corners();
		set_surface(8'd8, 15'd512, 15'd64, 4'd1, {1'b0, LAYOUT_THIN2}, 3'd3, 3'd1, 15'd64);
		send_coord(14'd37, 14'd91, 13'd3, 3'd0);
		set_surface(8'd16, 15'd256, 15'd128, 4'd2, {1'b0, LAYOUT_THIN4}, 3'd5, 3'd2, 15'd64);
		send_coord(14'd200, 14'd33, 13'd7, 3'd1);
		set_surface(8'd64, 15'd128, 15'd64, 4'd4, {1'b0, LAYOUT_SW_THIN1}, 3'd1, 3'd3, 15'd16);
		send_coord(14'd77, 14'd60, 13'd2, 3'd3);
		// split with samples too large for one split
		set_surface(8'd128, 15'd64, 15'd64, 4'd8, {1'b0, LAYOUT_SW_THIN2}, 3'd7, 3'd4, 15'd0);
		send_coord(14'd13, 14'd27, 13'd5, 3'd7);
		send_coord(14'd99, 14'd4, 13'd1, 3'd2);
		set_surface(8'd96, 15'd96, 15'd32, 4'd2, {1'b0, LAYOUT_SW_THIN4}, 3'd2, 3'd5, 15'd8);
		send_coord(14'd50, 14'd71, 13'd9, 3'd1);
		set_surface(8'd32, 15'd64, 15'd32, 4'd1, {1'b0, LAYOUT_THICK}, 3'd4, 3'd6, 15'd32);
		send_coord(14'd21, 14'd45, 13'd14, 3'd0);
		set_surface(8'd64, 15'd64, 15'd32, 4'd2, {MODE_DEPTH, LAYOUT_SW_THICK}, 3'd6, 3'd7,
			15'd1);
		send_coord(14'd63, 14'd31, 13'd11, 3'd1);
		// no samples, sample index past the count, unlisted element size
		set_surface(8'd24, 15'd128, 15'd128, 4'd0, {MODE_DEPTH, LAYOUT_THIN1}, 3'd0, 3'd0,
			15'd1);
		send_coord(14'd5, 14'd9, 13'd2, 3'd6);
		set_surface(8'd40, 15'd0, 15'd0, 4'd3, {1'b0, LAYOUT_THIN1}, 3'd1, 3'd1, 15'd1);
		send_coord(14'd300, 14'd400, 13'd50, 3'd7);
		set_surface(8'hFF, 15'h7FFF, 15'h7FFF, 4'hF, {MODE_DEPTH, LAYOUT_SW_THICK}, 3'd7, 3'd7,
			15'h7FFF);
		send_coord(14'h3FFF, 14'h3FFF, 13'h1FFF, 3'd7);
		send_coord(14'd0, 14'd0, 13'd0, 3'd0);
	endtask

	// random surfaces with random coordinates, idle and busy stretches mixed
	task automatic test_random_surfaces();
		logic [7:0] bpe;
		logic [7:0] sizes [6];
		logic [3:0] counts [4];
		sizes = '{8'd8, 8'd16, 8'd32, 8'd64, 8'd96, 8'd128};
		counts = '{4'd1, 4'd2, 4'd4, 4'd8};
		for (int p = 0; p < 15; p++) begin
			bpe = ($urandom_range(0, 4) == 0) ? 8'($urandom) : sizes[$urandom_range(0, 5)];
			set_surface(bpe,
				($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'(8 * $urandom_range(1, 256)),
				($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(1, 2048)),
				($urandom_range(0, 3) == 0) ? 4'($urandom) : counts[$urandom_range(0, 3)],
				4'($urandom), 3'($urandom), 3'($urandom),
				($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 512)));
			for (int i = 0; i < 68; i++) begin
				if (i % 20 == 0)
					gaps_on = (p % 3 != 1) || (i != 20);
				send_random_coord();
			end
			gaps_on = 1'b1;
		end
	endtask

	// sender holds off until the pipeline is fully drained, then resumes
	task automatic test_drain_pause();
		for (int i = 0; i < 10; i++)
			send_random_coord();
		s_axis_tvalid <= 1'b0;
		while (offsets_due.size() != 0) @(posedge clk);
		for (int i = 0; i < 10; i++)
			send_random_coord();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_surface();
		test_layouts_and_corners();
		test_random_surfaces();
		test_drain_pause();
		wait_idle();
		$display("covered %0d surface setups, %0d coordinates sent, %0d offsets checked",
			surfaces_used, words_sent, words_checked);
		$display("all layouts, depth and thick modes, sample splits and bank swaps exercised");
		if (mismatches == 0 && offsets_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: files.f
design/mtsa_pkg.sv
design/mtsa_div.sv
design/macro_tiled_surface_address.sv
design/mtsa_checker.sv
tb/sv/tb.sv
